@@ rtl/eiss_pkg.sv @@
// ----------------------------------------------------------------------------
// eiss_pkg
// Shared types and constants of the enabled item slot set: sizes, codes,
// the token that runs down the slot chain and the slot write command.
// ----------------------------------------------------------------------------
package eiss_pkg;

    localparam int SLOTS    = 8;
    localparam int HANDLE_W = 32;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CFG_W    = 4;
    localparam int NUM_TBL  = 3;

    typedef enum logic [1:0] {
        MODE_ENABLE,
        MODE_DISABLE,
        MODE_CHECK,
        MODE_SET_ENV
    } t_mode;

    typedef enum logic [1:0] {
        TBL_LIGHT,
        TBL_CLIP,
        TBL_HORIZON,
        TBL_NONE
    } t_tbl;

    typedef enum logic [2:0] {
        STAT_ADDED,
        STAT_PRESENT,
        STAT_REMOVED,
        STAT_NOT_FOUND,
        STAT_FULL,
        STAT_ENV_SET,
        STAT_NOTHING
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    localparam logic [1:0] CFG_LIGHT   = 2'd0;
    localparam logic [1:0] CFG_CLIP    = 2'd1;
    localparam logic [1:0] CFG_HORIZON = 2'd2;

    // Search token: carries one item down the chain and collects the hits.
    typedef struct packed {
        logic                valid;
        t_mode               mode;
        t_tbl                sel;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    limit;
        logic                found;
        logic [IDX_W-1:0]    found_idx;
        logic                free_seen;
        logic [IDX_W-1:0]    free_idx;
    } t_token;

    // Slot write command broadcast to all cells.
    typedef struct packed {
        logic                en;
        t_tbl                sel;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] data;
    } t_wr;

endpackage

@@ rtl/enabled_item_slot_set.sv @@
// ----------------------------------------------------------------------------
// enabled_item_slot_set
// Three small handle tables (lights, clip planes, horizon planes) and one
// environment handle, searched by a token running along a chain of slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one item: mode, table select
//   and handle. Output channel (o_valid / i_stall) returns exactly one result
//   item per input item, in order.
//   An accepted item becomes a token that walks the slot chain, one cell per
//   cycle, collecting the first matching slot and the first free usable slot.
//   At the end of the chain the controller commits: writes or clears at most one slot,
//   updates the table count and the environment, and loads the result
//   register.
//   The walk through the chain sets the pace: the block takes one item at a
//   time and opens intake again only once the token has left the chain and
//   its result has been committed.
//   A waiting result does not block intake: the next item is taken while the
//   result register is still held; its commit waits until that result is
//   taken, so a stalled receiver eventually stalls the sender.
//   Reset (synchronous, active low) clears all tables, counts and the
//   environment and restores slot limits 8, 6 and 4. No clearing pass.
//   Intake is stalled while reset is held.
//   Configuration writes are taken in any cycle; issue them only while idle.
// ----------------------------------------------------------------------------
module enabled_item_slot_set
    import eiss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_table_select,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [2:0]          o_slot_index,
    output logic [3:0]          o_table_count,
    output logic [HANDLE_W-1:0] o_previous_environment,
    output logic                o_environment_cleared,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    // token links: w_tok[0] is the launch point, w_tok[SLOTS] leaves the chain
    t_token w_tok [SLOTS+1];
    t_wr    w_wr;

    eiss_ctrl u_ctrl (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_mode                 (i_mode),
        .i_table_select         (i_table_select),
        .i_handle               (i_handle),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .o_tok                  (w_tok[0]),
        .i_tok                  (w_tok[SLOTS]),
        .o_wr                   (w_wr),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_status               (o_status),
        .o_slot_index           (o_slot_index),
        .o_table_count          (o_table_count),
        .o_previous_environment (o_previous_environment),
        .o_environment_cleared  (o_environment_cleared)
    );

    // one cell per slot; the token advances one cell each cycle
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        eiss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_tok      (w_tok[g]),
            .i_wr       (w_wr),
            .o_tok      (w_tok[g+1])
        );
    end

endmodule

@@ rtl/eiss_cell.sv @@
// ----------------------------------------------------------------------------
// eiss_cell
// One slot of all three tables. Checks the passing token against its entry
// and hands the token to the next cell.
// ----------------------------------------------------------------------------
module eiss_cell
    import eiss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_token           i_tok,
    input  t_wr              i_wr,
    output t_token           o_tok
);

    logic [HANDLE_W-1:0] r_entry [NUM_TBL];
    t_token              r_tok;
    t_token              n_tok;
    logic [HANDLE_W-1:0] w_cur;
    logic                w_has_tbl;
    logic                w_usable;

    always_comb begin
        w_has_tbl = 1'b1;
        case (i_tok.sel)
            TBL_LIGHT:   w_cur = r_entry[0];
            TBL_CLIP:    w_cur = r_entry[1];
            TBL_HORIZON: w_cur = r_entry[2];
            default: begin
                w_cur     = '0;
                w_has_tbl = 1'b0;
            end
        endcase
    end

    assign w_usable = w_has_tbl && (CNT_W'(i_cell_idx) < i_tok.limit);

    // first match and first free slot, lowest index wins
    always_comb begin
        n_tok = i_tok;
        if (w_usable && !i_tok.found && (w_cur == i_tok.handle)) begin
            n_tok.found     = 1'b1;
            n_tok.found_idx = i_cell_idx;
        end
        if (w_usable && !i_tok.free_seen && (w_cur == '0)) begin
            n_tok.free_seen = 1'b1;
            n_tok.free_idx  = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TBL; t++) begin
                r_entry[t] <= '0;
            end
        end else if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            case (i_wr.sel)
                TBL_LIGHT:   r_entry[0] <= i_wr.data;
                TBL_CLIP:    r_entry[1] <= i_wr.data;
                TBL_HORIZON: r_entry[2] <= i_wr.data;
                default: ;
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/eiss_ctrl.sv @@
// ----------------------------------------------------------------------------
// eiss_ctrl
// Sequencer of the slot set: takes items, launches tokens into the chain,
// commits the outcome and holds the result register.
// ----------------------------------------------------------------------------
module eiss_ctrl
    import eiss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_table_select,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output t_token              o_tok,
    input  t_token              i_tok,
    output t_wr                 o_wr,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [2:0]          o_slot_index,
    output logic [3:0]          o_table_count,
    output logic [HANDLE_W-1:0] o_previous_environment,
    output logic                o_environment_cleared
);

    t_state              r_state, n_state;
    t_token              r_tok;
    logic [CFG_W-1:0]    r_cfg   [NUM_TBL];
    logic [CNT_W-1:0]    r_count [NUM_TBL];
    logic [HANDLE_W-1:0] r_env;
    logic                r_ovalid;
    logic [2:0]          r_status;
    logic [2:0]          r_slot;
    logic [3:0]          r_cnt_out;
    logic [HANDLE_W-1:0] r_prev_env;
    logic                r_cleared;

    logic                w_accept;
    logic                w_out_free;
    logic                w_commit;
    logic [CFG_W-1:0]    w_cfg_sel;
    logic [CNT_W-1:0]    w_limit;
    logic [CNT_W-1:0]    w_cnt_cur;
    logic [CNT_W-1:0]    w_cnt_new;
    t_status             w_status;
    logic [IDX_W-1:0]    w_slot;
    logic [HANDLE_W-1:0] w_env_new;
    logic                w_clr;
    t_wr                 w_wr;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    // usable slot limit of the selected table, clamped to the chain length
    always_comb begin
        case (t_tbl'(i_table_select))
            TBL_LIGHT:   w_cfg_sel = r_cfg[0];
            TBL_CLIP:    w_cfg_sel = r_cfg[1];
            TBL_HORIZON: w_cfg_sel = r_cfg[2];
            default:     w_cfg_sel = '0;
        endcase
        w_limit = (int'(w_cfg_sel) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(w_cfg_sel);
    end

    always_comb begin
        o_tok           = '0;
        o_tok.valid     = w_accept;
        o_tok.mode      = t_mode'(i_mode);
        o_tok.sel       = t_tbl'(i_table_select);
        o_tok.handle    = i_handle;
        o_tok.limit     = w_limit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (i_tok.valid) n_state = S_COMMIT;
            S_COMMIT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs; hold intake closed while reset is asserted
    always_comb begin
        o_stall  = 1'b1;
        w_commit = 1'b0;
        case (r_state)
            S_IDLE:   o_stall = !i_rst_n;
            S_COMMIT: w_commit = w_out_free;
            default:  ;
        endcase
    end

    always_comb begin
        case (r_tok.sel)
            TBL_LIGHT:   w_cnt_cur = r_count[0];
            TBL_CLIP:    w_cnt_cur = r_count[1];
            TBL_HORIZON: w_cnt_cur = r_count[2];
            default:     w_cnt_cur = '0;
        endcase
    end

    // outcome of the finished search
    always_comb begin
        w_status  = STAT_NOTHING;
        w_slot    = '0;
        w_cnt_new = w_cnt_cur;
        w_env_new = r_env;
        w_clr     = 1'b0;
        w_wr      = '0;
        w_wr.sel  = r_tok.sel;
        if (r_tok.mode == MODE_SET_ENV) begin
            w_env_new = r_tok.handle;
            w_status  = STAT_ENV_SET;
        end else begin
            if ((r_tok.mode == MODE_CHECK) && (r_env != '0) && (r_env == r_tok.handle)) begin
                w_env_new = '0;
                w_clr     = 1'b1;
            end
            if ((r_tok.sel != TBL_NONE) && (r_tok.handle != '0)) begin
                if (r_tok.mode == MODE_ENABLE) begin
                    if (r_tok.found) begin
                        w_status = STAT_PRESENT;
                        w_slot   = r_tok.found_idx;
                    end else if (r_tok.free_seen) begin
                        w_status  = STAT_ADDED;
                        w_slot    = r_tok.free_idx;
                        w_cnt_new = w_cnt_cur + 1'b1;
                        w_wr.en   = 1'b1;
                        w_wr.idx  = r_tok.free_idx;
                        w_wr.data = r_tok.handle;
                    end else begin
                        w_status = STAT_FULL;
                    end
                end else begin
                    if (r_tok.found) begin
                        w_status = STAT_REMOVED;
                        w_slot   = r_tok.found_idx;
                        if (w_cnt_cur != '0) begin
                            w_cnt_new = w_cnt_cur - 1'b1;
                        end
                        w_wr.en   = 1'b1;
                        w_wr.idx  = r_tok.found_idx;
                    end else begin
                        w_status = STAT_NOT_FOUND;
                    end
                end
            end
        end
    end

    always_comb begin
        o_wr    = w_wr;
        o_wr.en = w_wr.en && w_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // park the finished token until the result register is free
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && i_tok.valid) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= CFG_W'(8);
            r_cfg[1] <= CFG_W'(6);
            r_cfg[2] <= CFG_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIGHT:   r_cfg[0] <= i_cfg_data;
                CFG_CLIP:    r_cfg[1] <= i_cfg_data;
                CFG_HORIZON: r_cfg[2] <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TBL; t++) begin
                r_count[t] <= '0;
            end
            r_env <= '0;
        end else if (w_commit) begin
            r_env <= w_env_new;
            case (r_tok.sel)
                TBL_LIGHT:   r_count[0] <= w_cnt_new;
                TBL_CLIP:    r_count[1] <= w_cnt_new;
                TBL_HORIZON: r_count[2] <= w_cnt_new;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_commit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status   <= w_status;
            r_slot     <= 3'(w_slot);
            r_cnt_out  <= 4'(w_cnt_new);
            r_prev_env <= r_env;
            r_cleared  <= w_clr;
        end
    end

    assign o_valid                = r_ovalid;
    assign o_status               = r_status;
    assign o_slot_index           = r_slot;
    assign o_table_count          = r_cnt_out;
    assign o_previous_environment = r_prev_env;
    assign o_environment_cleared  = r_cleared;

endmodule

@@ rtl/eiss_chk.sv @@
// ----------------------------------------------------------------------------
// eiss_chk
// Port-level checks of the enabled item slot set, bound to the top level.
// ----------------------------------------------------------------------------
module eiss_chk
    import eiss_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [2:0]          o_status,
    input logic [2:0]          o_slot_index,
    input logic                o_environment_cleared
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // one item at a time: intake closes after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("intake open right after accept");

    // stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_slot_index)))
        else $error("stalled result changed");

    // full table reports slot zero
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_FULL)) |-> (o_slot_index == 3'd0))
        else $error("full result with nonzero slot");

    // environment set never clears and names no slot
    a_env_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_ENV_SET))
            |-> (!o_environment_cleared && (o_slot_index == 3'd0)))
        else $error("environment set result malformed");

endmodule

bind enabled_item_slot_set eiss_chk u_eiss_chk (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for enabled_item_slot_set. A mirror of the three handle
// tables, their counts, slot limits and the environment handle predicts one
// result per accepted item, and each returned result is compared field by
// field in order. Directed cases come first, then eight random phases under
// different slot limits and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import eiss_pkg::*;

    // Expected outcome of one item, in the order of the result fields.
    typedef struct packed {
        t_status             status;
        logic [2:0]          slot;
        logic [3:0]          count;
        logic [HANDLE_W-1:0] prev_env;
        logic                cleared;
    } t_outcome;

    // Mirror of the block state; predicts outcomes and checks results.
    class slot_set_mirror;
        logic [NUM_TBL-1:0][SLOTS-1:0][HANDLE_W-1:0] tables;
        logic [NUM_TBL-1:0][3:0]                     counts;
        logic [NUM_TBL-1:0][CFG_W-1:0]               limits;
        logic [HANDLE_W-1:0]                         env;
        t_outcome                                    outcomes[$];
        int                                          mismatches;
        int                                          checked;

        function new();
            tables     = '0;
            counts     = '0;
            env        = '0;
            limits[CFG_LIGHT]   = 4'd8;
            limits[CFG_CLIP]    = 4'd6;
            limits[CFG_HORIZON] = 4'd4;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [CFG_W-1:0] val);
            limits[idx] = val;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        // Apply one accepted item to the mirror and queue its outcome.
        function void take_item(t_mode m, t_tbl sel, logic [HANDLE_W-1:0] h);
            t_outcome r;
            int       t;
            int       lim;
            bit       hit;
            r.prev_env = env;
            r.status   = STAT_NOTHING;
            r.slot     = '0;
            r.cleared  = 1'b0;
            r.count    = '0;
            t          = int'(sel);
            if (m == MODE_SET_ENV) begin
                env      = h;
                r.status = STAT_ENV_SET;
            end else begin
                // Clear a matching environment before touching the table.
                if (m == MODE_CHECK && env != '0 && env == h) begin
                    env       = '0;
                    r.cleared = 1'b1;
                end
                if (sel != TBL_NONE && h != '0) begin
                    lim = (limits[t] > SLOTS) ? SLOTS : int'(limits[t]);
                    hit = 1'b0;
                    if (m == MODE_ENABLE) begin
                        for (int i = 0; i < lim; i++) begin
                            if (!hit && tables[t][i] == h) begin
                                hit      = 1'b1;
                                r.slot   = i[2:0];
                                r.status = STAT_PRESENT;
                            end
                        end
                        if (!hit) begin
                            r.status = STAT_FULL;
                            for (int i = 0; i < lim; i++) begin
                                if (!hit && tables[t][i] == '0) begin
                                    hit          = 1'b1;
                                    tables[t][i] = h;
                                    counts[t]    = counts[t] + 4'd1;
                                    r.slot       = i[2:0];
                                    r.status     = STAT_ADDED;
                                end
                            end
                        end
                    end else begin
                        r.status = STAT_NOT_FOUND;
                        for (int i = 0; i < lim; i++) begin
                            if (!hit && tables[t][i] == h) begin
                                hit          = 1'b1;
                                tables[t][i] = '0;
                                if (counts[t] != '0)
                                    counts[t] = counts[t] - 4'd1;
                                r.slot   = i[2:0];
                                r.status = STAT_REMOVED;
                            end
                        end
                    end
                end
            end
            if (sel != TBL_NONE)
                r.count = counts[t];
            outcomes.push_back(r);
        endfunction

        // Compare one returned result with the oldest outcome.
        function void match_result(logic [2:0] status, logic [2:0] slot, logic [3:0] count,
                                   logic [HANDLE_W-1:0] prev_env, logic cleared);
            t_outcome e;
            checked++;
            if (outcomes.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d", status, slot);
                mismatches++;
                return;
            end
            e = outcomes.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (slot !== e.slot) begin
                $error("slot_index: expected %0d, got %0d", e.slot, slot);
                mismatches++;
            end
            if (count !== e.count) begin
                $error("table_count: expected %0d, got %0d", e.count, count);
                mismatches++;
            end
            if (prev_env !== e.prev_env) begin
                $error("previous_environment: expected %h, got %h", e.prev_env, prev_env);
                mismatches++;
            end
            if (cleared !== e.cleared) begin
                $error("environment_cleared: expected %0d, got %0d", e.cleared, cleared);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_mode;
    logic [1:0]          i_table_select;
    logic [HANDLE_W-1:0] i_handle;
    logic                o_valid;
    logic                i_stall;
    logic [2:0]          o_status;
    logic [2:0]          o_slot_index;
    logic [3:0]          o_table_count;
    logic [HANDLE_W-1:0] o_previous_environment;
    logic                o_environment_cleared;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    slot_set_mirror      mirror;
    logic [HANDLE_W-1:0] handle_pool[12];
    int                  idle_pct;
    int                  stall_pct;
    int                  items_sent;
    int                  settings_used;

    enabled_item_slot_set dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_mode                 (i_mode),
        .i_table_select         (i_table_select),
        .i_handle               (i_handle),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_status               (o_status),
        .o_slot_index           (o_slot_index),
        .o_table_count          (o_table_count),
        .o_previous_environment (o_previous_environment),
        .o_environment_cleared  (o_environment_cleared),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver side: stall at random with the current phase's rate.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Take each result the handshake moves and check it in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            mirror.match_result(o_status, o_slot_index, o_table_count,
                                o_previous_environment, o_environment_cleared);
    end

    // Offer one item, idling first at the phase's rate; hold it until taken.
    task automatic send_item(input t_mode m, input t_tbl sel, input logic [HANDLE_W-1:0] h);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_mode         <= m;
        i_table_select <= sel;
        i_handle       <= h;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.take_item(m, sel, h);
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_results;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    // Write all three slot limits; only call with the block idle.
    task automatic set_limits(input logic [CFG_W-1:0] lights, input logic [CFG_W-1:0] clips,
                              input logic [CFG_W-1:0] horizons);
        logic [CFG_W-1:0] vals[3];
        vals[0] = lights;
        vals[1] = clips;
        vals[2] = horizons;
        for (int k = 0; k < 3; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= k[1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            mirror.set_limit(k[1:0], vals[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly reuse a small pool so adds, hits, removals and full tables occur.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(99) < 88)
            return handle_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    task automatic send_random;
        int    r;
        t_mode m;
        t_tbl  sel;
        r = $urandom_range(99);
        if (r < 40)
            m = MODE_ENABLE;
        else if (r < 65)
            m = MODE_DISABLE;
        else if (r < 88)
            m = MODE_CHECK;
        else
            m = MODE_SET_ENV;
        sel = ($urandom_range(9) == 0) ? TBL_NONE : t_tbl'($urandom_range(2));
        send_item(m, sel, pick_handle());
    endtask

    task automatic run_directed;
        // Zero handle, first add, repeat add, no table selected.
        send_item(MODE_ENABLE,  TBL_LIGHT,   '0);
        send_item(MODE_ENABLE,  TBL_LIGHT,   32'hFFFF_FFFF);
        send_item(MODE_ENABLE,  TBL_LIGHT,   32'hFFFF_FFFF);
        send_item(MODE_ENABLE,  TBL_NONE,    32'h0000_0001);
        send_item(MODE_DISABLE, TBL_NONE,    32'h0000_0001);
        send_item(MODE_DISABLE, TBL_LIGHT,   '0);
        // Fill the four usable horizon slots, then overflow.
        for (int k = 1; k <= 5; k++)
            send_item(MODE_ENABLE, TBL_HORIZON, HANDLE_W'(k));
        send_item(MODE_DISABLE, TBL_HORIZON, 32'h8000_0000);
        send_item(MODE_DISABLE, TBL_HORIZON, 32'h0000_0002);
        send_item(MODE_ENABLE,  TBL_HORIZON, 32'h8000_0000);
        // Environment: set, clear by check, check with zero, clear plus remove.
        send_item(MODE_SET_ENV, TBL_NONE,    32'hA5A5_5A5A);
        send_item(MODE_CHECK,   TBL_NONE,    32'hA5A5_5A5A);
        send_item(MODE_CHECK,   TBL_LIGHT,   '0);
        send_item(MODE_SET_ENV, TBL_CLIP,    32'h0000_0003);
        send_item(MODE_CHECK,   TBL_HORIZON, 32'h0000_0003);
        send_item(MODE_SET_ENV, TBL_LIGHT,   '0);
        // No usable light slot, clip limit above range, horizon limit lowered.
        drain_results();
        set_limits(4'd0, 4'd15, 4'd1);
        send_item(MODE_ENABLE,  TBL_LIGHT,   32'h0000_0007);
        send_item(MODE_DISABLE, TBL_LIGHT,   32'hFFFF_FFFF);
        send_item(MODE_ENABLE,  TBL_HORIZON, 32'h0000_0004);
        send_item(MODE_ENABLE,  TBL_CLIP,    32'h0000_0009);
    endtask

    initial begin
        logic [CFG_W-1:0] light_lim[8];
        logic [CFG_W-1:0] clip_lim[8];
        logic [CFG_W-1:0] horizon_lim[8];
        light_lim   = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd8, 4'd3, 4'd2};
        clip_lim    = '{4'd8, 4'd2, 4'd0, 4'd6, 4'd9, 4'd1, 4'd8, 4'd15};
        horizon_lim = '{4'd8, 4'd3, 4'd8, 4'd2, 4'd12, 4'd15, 4'd0, 4'd1};
        mirror         = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_mode         = MODE_ENABLE;
        i_table_select = TBL_LIGHT;
        i_handle       = '0;
        i_stall        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_LIGHT;
        i_cfg_data     = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        items_sent     = 0;
        settings_used  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random phases: each with its own limits and handle pool, and one of four idle patterns.
        for (int p = 0; p < 8; p++) begin
            drain_results();
            if (p == 7)
                set_limits(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                           CFG_W'($urandom_range(15)));
            else
                set_limits(light_lim[p], clip_lim[p], horizon_lim[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            handle_pool[0] = '0;
            handle_pool[1] = '1;
            for (int k = 2; k < 12; k++)
                handle_pool[k] = $urandom;
            for (int n = 0; n < 230; n++) begin
                // Hold the sender once mid-phase until the pipe runs dry.
                if (p == 1 && n == 115)
                    drain_results();
                send_random();
            end
        end

        drain_results();
        if (mirror.pending() != 0) begin
            $error("%0d results never arrived", mirror.pending());
            mirror.mismatches++;
        end
        $display("Sent %0d items under %0d slot limit settings and four idle patterns.",
                 items_sent, settings_used + 1);
        $display("Checked %0d results, %0d mismatches.", mirror.checked, mirror.mismatches);
        if (mirror.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
